FILE: design/wcds_pkg.sv
// ----------------------------------------------------------------------------
// Wake calibration deadline sequencer package
// Shared command codes, register indexes, reset values and word types.
// ----------------------------------------------------------------------------
package wcds_pkg;

  localparam int unsigned CmdW   = 4;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RegW   = 24;
  localparam int unsigned RegIdxW = 2;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_RESET         = 4'd0;
  localparam logic [CmdW-1:0] CMD_SET_PROMPT    = 4'd1;
  localparam logic [CmdW-1:0] CMD_BEGIN_CALIB   = 4'd2;
  localparam logic [CmdW-1:0] CMD_CALIB_DONE    = 4'd3;
  localparam logic [CmdW-1:0] CMD_RESTORE       = 4'd4;
  localparam logic [CmdW-1:0] CMD_LIFT_READY    = 4'd5;
  localparam logic [CmdW-1:0] CMD_SET_ARMED     = 4'd6;
  localparam logic [CmdW-1:0] CMD_SET_START     = 4'd7;
  localparam logic [CmdW-1:0] CMD_BEGIN_CONFIRM = 4'd8;
  localparam logic [CmdW-1:0] CMD_CANCEL_CONFIRM = 4'd9;
  localparam logic [CmdW-1:0] CMD_BEGIN_NET     = 4'd10;
  localparam logic [CmdW-1:0] CMD_CANCEL_NET    = 4'd11;
  localparam logic [CmdW-1:0] CMD_FALSE_WAKE    = 4'd12;
  localparam logic [CmdW-1:0] CMD_CLEAR_FALSE_WAKE = 4'd13;
  localparam logic [CmdW-1:0] CMD_CANCEL_PENDING = 4'd14;
  localparam logic [CmdW-1:0] CMD_TICK          = 4'd15;

  // Configuration register indexes.
  localparam logic [RegIdxW-1:0] REG_CALIB_TIMEOUT  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_CONFIRM_WINDOW = 2'd1;
  localparam logic [RegIdxW-1:0] REG_NETWORK_WAIT   = 2'd2;

  localparam logic [RegW-1:0] CALIB_TIMEOUT_RST  = 24'd5000;
  localparam logic [RegW-1:0] CONFIRM_WINDOW_RST = 24'd1000;
  localparam logic [RegW-1:0] NETWORK_WAIT_RST   = 24'd10000;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic             flag_value;
    logic             prior_calibration;
    logic [TimeW-1:0] time_now;
    logic [TimeW-1:0] until_time;
  } item_t;

  typedef struct packed {
    logic calib_active;
    logic calib_had_prior;
    logic prompt_visible;
    logic lift_ready_armed;
    logic start_waiting;
    logic confirm_waiting;
    logic network_waiting;
    logic calib_timeout_hit;
    logic confirm_time_hit;
    logic network_timeout_hit;
    logic false_wake_hit;
  } res_t;

  typedef struct packed {
    logic [RegW-1:0] calib_timeout;
    logic [RegW-1:0] confirm_window;
    logic [RegW-1:0] network_wait_limit;
  } cfg_t;

  // Which deadlines currently hold a nonzero value.
  typedef struct packed {
    logic calib;
    logic confirm;
    logic network;
  } dl_set_t;

endpackage

FILE: design/wcds_if.sv
// ----------------------------------------------------------------------------
// Wake calibration deadline sequencer channel interfaces
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface wcds_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic        flag_value;
  logic        prior_calibration;
  logic [31:0] time_now;
  logic [31:0] until_time;

  modport source (output valid, cmd, flag_value, prior_calibration, time_now, until_time,
                  input ready);
  modport sink (input valid, cmd, flag_value, prior_calibration, time_now, until_time,
                output ready);
endinterface

interface wcds_out_if;
  logic valid;
  logic ready;
  logic calib_active;
  logic calib_had_prior;
  logic prompt_visible;
  logic lift_ready_armed;
  logic start_waiting;
  logic confirm_waiting;
  logic network_waiting;
  logic calib_timeout_hit;
  logic confirm_time_hit;
  logic network_timeout_hit;
  logic false_wake_hit;

  modport source (output valid, calib_active, calib_had_prior, prompt_visible,
                  lift_ready_armed, start_waiting, confirm_waiting, network_waiting,
                  calib_timeout_hit, confirm_time_hit, network_timeout_hit,
                  false_wake_hit, input ready);
  modport sink (input valid, calib_active, calib_had_prior, prompt_visible,
                lift_ready_armed, start_waiting, confirm_waiting, network_waiting,
                calib_timeout_hit, confirm_time_hit, network_timeout_hit,
                false_wake_hit, output ready);
endinterface

interface wcds_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/wcds_cfg.sv
// ----------------------------------------------------------------------------
// Wake calibration deadline sequencer configuration registers
// Holds the three timeout registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module wcds_cfg
  import wcds_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [RegIdxW-1:0] wr_idx,
  input  logic [RegW-1:0]    wr_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        REG_CALIB_TIMEOUT:  cfg_nxt.calib_timeout      = wr_data;
        REG_CONFIRM_WINDOW: cfg_nxt.confirm_window     = wr_data;
        REG_NETWORK_WAIT:   cfg_nxt.network_wait_limit = wr_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.calib_timeout      <= CALIB_TIMEOUT_RST;
      cfg_r.confirm_window     <= CONFIRM_WINDOW_RST;
      cfg_r.network_wait_limit <= NETWORK_WAIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/wcds_core.sv
// ----------------------------------------------------------------------------
// Wake calibration deadline sequencer state core
// Mode flags, deadlines and due flags, with the per-command update logic.
// ----------------------------------------------------------------------------
module wcds_core
  import wcds_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  item_t   item,
  input  cfg_t    cfg,
  output res_t    nxt_snap,
  output res_t    cur_snap,
  output dl_set_t dl_set
);

  logic             calib_active_r, calib_active_nxt;
  logic             calib_prior_r, calib_prior_nxt;
  logic             prompt_r, prompt_nxt;
  logic             armed_r, armed_nxt;
  logic             start_r, start_nxt;
  logic             confirm_r, confirm_nxt;
  logic             network_r, network_nxt;
  logic [TimeW-1:0] calib_dl_r, calib_dl_nxt;
  logic [TimeW-1:0] confirm_dl_r, confirm_dl_nxt;
  logic [TimeW-1:0] network_dl_r, network_dl_nxt;
  logic [TimeW-1:0] fw_dl_r, fw_dl_nxt;
  logic [3:0]       due_r, due_nxt;

  logic [RegW-1:0]  tmo_sel;
  logic [TimeW:0]   dl_sum;
  logic [TimeW-1:0] dl_sat;
  logic [3:0]       due_hit;

  // One shared adder serves all three begin commands.
  always_comb begin
    case (item.cmd)
      CMD_BEGIN_CALIB:   tmo_sel = cfg.calib_timeout;
      CMD_BEGIN_CONFIRM: tmo_sel = cfg.confirm_window;
      default:           tmo_sel = cfg.network_wait_limit;
    endcase
  end

  assign dl_sum = {1'b0, item.time_now} + {{(TimeW + 1 - RegW){1'b0}}, tmo_sel};
  assign dl_sat = dl_sum[TimeW] ? {TimeW{1'b1}} : dl_sum[TimeW-1:0];

  assign due_hit[0] = calib_active_r && (calib_dl_r != '0) && (item.time_now >= calib_dl_r);
  assign due_hit[1] = confirm_r && (confirm_dl_r != '0) && (item.time_now >= confirm_dl_r);
  assign due_hit[2] = network_r && (network_dl_r != '0) && (item.time_now >= network_dl_r);
  assign due_hit[3] = (fw_dl_r != '0) && (item.time_now >= fw_dl_r);

  always_comb begin
    calib_active_nxt = calib_active_r;
    calib_prior_nxt  = calib_prior_r;
    prompt_nxt       = prompt_r;
    armed_nxt        = armed_r;
    start_nxt        = start_r;
    confirm_nxt      = confirm_r;
    network_nxt      = network_r;
    calib_dl_nxt     = calib_dl_r;
    confirm_dl_nxt   = confirm_dl_r;
    network_dl_nxt   = network_dl_r;
    fw_dl_nxt        = fw_dl_r;
    due_nxt          = due_r;
    case (item.cmd)
      CMD_RESET: begin
        calib_active_nxt = 1'b0;
        calib_prior_nxt  = 1'b0;
        prompt_nxt       = 1'b0;
        armed_nxt        = 1'b0;
        start_nxt        = 1'b0;
        confirm_nxt      = 1'b0;
        network_nxt      = 1'b0;
        calib_dl_nxt     = '0;
        confirm_dl_nxt   = '0;
        network_dl_nxt   = '0;
        fw_dl_nxt        = '0;
        due_nxt          = '0;
      end
      CMD_SET_PROMPT: prompt_nxt = item.flag_value;
      CMD_BEGIN_CALIB: begin
        calib_active_nxt = 1'b1;
        calib_prior_nxt  = item.prior_calibration;
        calib_dl_nxt     = dl_sat;
        fw_dl_nxt        = '0;
        armed_nxt        = 1'b0;
        start_nxt        = 1'b0;
        confirm_nxt      = 1'b0;
        confirm_dl_nxt   = '0;
        network_nxt      = 1'b0;
        network_dl_nxt   = '0;
      end
      CMD_CALIB_DONE, CMD_RESTORE, CMD_LIFT_READY: begin
        calib_active_nxt = 1'b0;
        calib_dl_nxt     = '0;
        calib_prior_nxt  = 1'b0;
        armed_nxt        = (item.cmd == CMD_CALIB_DONE);
        start_nxt        = 1'b0;
      end
      CMD_SET_ARMED: armed_nxt = item.flag_value;
      CMD_SET_START: start_nxt = item.flag_value;
      CMD_BEGIN_CONFIRM: begin
        confirm_nxt    = 1'b1;
        confirm_dl_nxt = dl_sat;
        armed_nxt      = 1'b0;
        start_nxt      = 1'b0;
        network_nxt    = 1'b0;
        network_dl_nxt = '0;
      end
      CMD_CANCEL_CONFIRM: begin
        confirm_nxt    = 1'b0;
        confirm_dl_nxt = '0;
      end
      CMD_BEGIN_NET: begin
        network_nxt    = 1'b1;
        network_dl_nxt = dl_sat;
        start_nxt      = 1'b1;
        armed_nxt      = 1'b0;
      end
      CMD_CANCEL_NET: begin
        network_nxt    = 1'b0;
        network_dl_nxt = '0;
      end
      CMD_FALSE_WAKE:       fw_dl_nxt = item.until_time;
      CMD_CLEAR_FALSE_WAKE: fw_dl_nxt = '0;
      CMD_CANCEL_PENDING: begin
        armed_nxt      = 1'b0;
        start_nxt      = 1'b0;
        confirm_nxt    = 1'b0;
        confirm_dl_nxt = '0;
        network_nxt    = 1'b0;
        network_dl_nxt = '0;
      end
      CMD_TICK: due_nxt = due_hit;
      default:  due_nxt = due_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_active_r <= 1'b0;
      calib_prior_r  <= 1'b0;
      prompt_r       <= 1'b0;
      armed_r        <= 1'b0;
      start_r        <= 1'b0;
      confirm_r      <= 1'b0;
      network_r      <= 1'b0;
      calib_dl_r     <= '0;
      confirm_dl_r   <= '0;
      network_dl_r   <= '0;
      fw_dl_r        <= '0;
      due_r          <= '0;
    end else if (adv) begin
      calib_active_r <= calib_active_nxt;
      calib_prior_r  <= calib_prior_nxt;
      prompt_r       <= prompt_nxt;
      armed_r        <= armed_nxt;
      start_r        <= start_nxt;
      confirm_r      <= confirm_nxt;
      network_r      <= network_nxt;
      calib_dl_r     <= calib_dl_nxt;
      confirm_dl_r   <= confirm_dl_nxt;
      network_dl_r   <= network_dl_nxt;
      fw_dl_r        <= fw_dl_nxt;
      due_r          <= due_nxt;
    end
  end

  assign nxt_snap = '{calib_active_nxt, calib_prior_nxt, prompt_nxt, armed_nxt, start_nxt,
                      confirm_nxt, network_nxt, due_nxt[0], due_nxt[1], due_nxt[2],
                      due_nxt[3]};
  assign cur_snap = '{calib_active_r, calib_prior_r, prompt_r, armed_r, start_r,
                      confirm_r, network_r, due_r[0], due_r[1], due_r[2], due_r[3]};
  assign dl_set = '{(calib_dl_r != '0), (confirm_dl_r != '0), (network_dl_r != '0)};

endmodule

FILE: design/wake_calibration_deadline_sequencer_top.sv
// ----------------------------------------------------------------------------
// Wake calibration deadline sequencer
// Command-driven mode flags, millisecond deadlines and due flags.
// ----------------------------------------------------------------------------
// Each command word on in_ch updates the sequencer state and produces one
// result word on out_ch holding the full flag snapshot after that command.
// A word is registered at the input, then its state update and snapshot are
// computed combinationally (one 33-bit saturating add for the begin commands and
// four 32-bit deadline compares for the tick) and land in the output register
// together with the state registers. Throughput is one word per cycle while
// out_ch.ready holds. The result is registered in the output register once
// the word leaves the input register; the input register and the output
// register form a two-deep pipeline, so a new word is taken while a finished
// result still waits on out_ch.ready.
// The three timeout registers are written through cfg_ch, which is always
// ready outside reset; they should only be changed while no word is in flight.
// A deadline of zero never fires, and begin-command deadlines saturate at the
// largest 32-bit time value.
module wake_calibration_deadline_sequencer_top
  import wcds_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  wcds_in_if.sink      in_ch,
  wcds_out_if.source   out_ch,
  wcds_cfg_if.sink     cfg_ch
);

  // Input register stage.
  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    s1_adv;
  logic    in_acc;

  // Output register stage.
  logic    out_valid_r, out_valid_nxt;
  res_t    out_res_r;

  cfg_t    cfg;
  res_t    nxt_snap;
  res_t    cur_snap;
  dl_set_t dl_set;

  // The word in the input register moves on whenever the output register is
  // empty or is being emptied this cycle.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = rst_n && (!s1_valid_r || s1_adv);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = rst_n;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= '{in_ch.cmd, in_ch.flag_value, in_ch.prior_calibration,
                     in_ch.time_now, in_ch.until_time};
    end
    if (s1_adv) begin
      out_res_r <= nxt_snap;
    end
  end

  wcds_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid && cfg_ch.ready),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  wcds_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (s1_adv),
    .item     (s1_item_r),
    .cfg      (cfg),
    .nxt_snap (nxt_snap),
    .cur_snap (cur_snap),
    .dl_set   (dl_set)
  );

  assign out_ch.valid               = out_valid_r;
  assign out_ch.calib_active        = out_res_r.calib_active;
  assign out_ch.calib_had_prior     = out_res_r.calib_had_prior;
  assign out_ch.prompt_visible      = out_res_r.prompt_visible;
  assign out_ch.lift_ready_armed    = out_res_r.lift_ready_armed;
  assign out_ch.start_waiting       = out_res_r.start_waiting;
  assign out_ch.confirm_waiting     = out_res_r.confirm_waiting;
  assign out_ch.network_waiting     = out_res_r.network_waiting;
  assign out_ch.calib_timeout_hit   = out_res_r.calib_timeout_hit;
  assign out_ch.confirm_time_hit    = out_res_r.confirm_time_hit;
  assign out_ch.network_timeout_hit = out_res_r.network_timeout_hit;
  assign out_ch.false_wake_hit      = out_res_r.false_wake_hit;

  // A pending deadline is only ever held while its mode flag is set.
  a_calib_dl_flag: assert property (@(posedge clk) disable iff (!rst_n)
    dl_set.calib |-> cur_snap.calib_active)
    else $error("calibration deadline set while calibration is inactive");

  a_confirm_dl_flag: assert property (@(posedge clk) disable iff (!rst_n)
    dl_set.confirm |-> cur_snap.confirm_waiting)
    else $error("confirm deadline set while confirm is not pending");

  a_network_dl_flag: assert property (@(posedge clk) disable iff (!rst_n)
    dl_set.network |-> cur_snap.network_waiting)
    else $error("network deadline set while network wait is not pending");

  // A word leaving the input register always shows up as a result next cycle.
  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced word did not reach the output register");

endmodule
